[rtl/spg_pkg.sv]
// ----------------------------------------------------------------------------
// spg_pkg
// Shared types and constants for the step/dir generator with homing.
// ----------------------------------------------------------------------------
`default_nettype none

package spg_pkg;

    // command codes carried in the op field
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_SPEED = 2'd1;
    localparam logic [1:0] OP_HOME  = 2'd2;
    localparam logic [1:0] OP_LIMIT = 2'd3;

    // register index (byte address bits [3:2])
    localparam logic [1:0] REG_LEAD  = 2'd0;
    localparam logic [1:0] REG_SPR   = 2'd1;
    localparam logic [1:0] REG_UPNEG = 2'd2;

    localparam int LEAD_W    = 17;
    localparam int SPR_W     = 16;
    localparam int SPEED_W   = 21;
    localparam int LOAD_W    = 24;
    localparam int POS_W     = 32;
    localparam int STEP_W    = 32;

    // shared multiplier operand widths
    localparam int MUL_A_W   = 32;
    localparam int MUL_B_W   = 26;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    // steps_per_rev * |speed|
    localparam int SPD_DEN_W = SPR_W + SPEED_W;

    // divider quotient and iteration count
    localparam int QUOT_W    = 32;
    localparam int QBITS_W   = 6;
    localparam int POS_QBITS = 32;

    localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic               start;
        logic [QBITS_W-1:0] qbits;
    } div_ctl_t;

    typedef struct packed {
        logic done;
        logic ovf;
    } div_sts_t;

endpackage

`default_nettype wire

[rtl/spg_div.sv]
// ----------------------------------------------------------------------------
// spg_div
// Shift-subtract divider, one quotient bit per cycle, with overflow check.
// ----------------------------------------------------------------------------
`default_nettype none

module spg_div
    import spg_pkg::*;
#(
    parameter int W = 69
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire div_ctl_t          ctl,
    input  wire logic [W-1:0]      num,
    input  wire logic [W-1:0]      den,
    output div_sts_t               sts,
    output logic [QUOT_W-1:0]      quot
);

    localparam logic [1:0] D_IDLE  = 2'd0;
    localparam logic [1:0] D_CHECK = 2'd1;
    localparam logic [1:0] D_ITER  = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [W-1:0]       rem_reg, rem_next;
    logic [W-1:0]       dsh_reg, dsh_next;
    logic [QUOT_W-1:0]  quot_reg, quot_next;
    logic [QBITS_W-1:0] cnt_reg, cnt_next;
    logic               ovf_reg, ovf_next;
    logic               done_reg, done_next;
    logic               ge;
    logic [W-1:0]       diff;

    assign ge   = rem_reg >= dsh_reg;
    assign diff = rem_reg - dsh_reg;

    always_comb begin
        state_next = state_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        quot_next  = quot_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        done_next  = 1'b0;
        case (state_reg)
            D_IDLE: begin
                if (ctl.start) begin
                    rem_next   = num;
                    dsh_next   = den << ctl.qbits;
                    quot_next  = '0;
                    cnt_next   = ctl.qbits;
                    state_next = D_CHECK;
                end
            end
            D_CHECK: begin
                // quotient does not fit in qbits: report and stop
                if (ge) begin
                    ovf_next   = 1'b1;
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end else begin
                    ovf_next   = 1'b0;
                    dsh_next   = dsh_reg >> 1;
                    state_next = D_ITER;
                end
            end
            D_ITER: begin
                quot_next = {quot_reg[QUOT_W-2:0], ge};
                if (ge) begin
                    rem_next = diff;
                end
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - QBITS_W'(1);
                if (cnt_reg == QBITS_W'(1)) begin
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default: begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
        cnt_reg  <= cnt_next;
        ovf_reg  <= ovf_next;
    end

    assign sts.done = done_reg;
    assign sts.ovf  = ovf_reg;
    assign quot     = quot_reg;

endmodule

`default_nettype wire

[rtl/stepper_pulse_generator_homing_top.sv]
// ----------------------------------------------------------------------------
// stepper_pulse_generator_homing_top
// Step/dir generator for a lead-screw stepper with position limit and homing.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (s_*): one word per timer tick or command. op selects
//    tick, set speed, start homing or set position limit. Ticks advance the
//    step timer; commands act at once.
//  - Result channel (m_*): exactly one word per input word, showing the pin
//    levels, run flag, step count and position after that word.
//  - APB port: lead_um (0x0), steps_per_rev (0x4), up_is_negative (0x8).
//    Write only while the block is idle. pready is tied high.
//  - Sequencing: a tick that needs no new position goes through EXEC,
//    POS_CHK and FINAL; a new word is taken only after FINAL. A running
//    speed command adds SPD_DEN, SPD_NUM and a PERIOD_WIDTH-bit divide. A word
//    that moves the step count, or follows a lead or steps_per_rev write, adds
//    the position divide (32 quotient bits) on the shared shift-subtract divider.
//  - s_ready is high only while the sequencer is idle. A finished result
//    waits in the output register, so a stalled m_ready holds the block in
//    its last step until the slot frees; no word is dropped.
//  - Reset (aresetn low, synchronous) restores the register defaults, stops
//    the motor and clears all counters.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_pulse_generator_homing_top
    import spg_pkg::*;
#(
    parameter int TICKS_PER_MS = 250,
    parameter int PERIOD_WIDTH = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,

    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [1:0]                s_op,
    input  wire logic signed [SPEED_W-1:0] s_speed_um_s,
    input  wire logic signed [LOAD_W-1:0]  s_load_threshold,
    input  wire logic signed [POS_W-1:0]   s_target_position_um,
    input  wire logic                      s_limit_enable,
    input  wire logic signed [LOAD_W-1:0]  s_load_sample,

    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_step_pulse,
    output logic                           m_direction,
    output logic                           m_running,
    output logic signed [STEP_W-1:0]       m_step_count,
    output logic signed [POS_W-1:0]        m_position_um,
    output logic                           m_homing_done,
    output logic                           m_limit_stop,

    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [3:0]                paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    // half-period numerator constant: ticks per second / 2
    localparam int HALF_K = 1000 * TICKS_PER_MS / 2;
    // divider width: holds den << PERIOD_WIDTH and any product
    localparam int DIV_W  = (SPD_DEN_W + PERIOD_WIDTH > MUL_P_W) ?
                            (SPD_DEN_W + PERIOD_WIDTH) : MUL_P_W;
    localparam logic [PERIOD_WIDTH-1:0] PMAX = {PERIOD_WIDTH{1'b1}};

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_EXEC     = 4'd1;
    localparam logic [3:0] S_SPD_DEN  = 4'd2;
    localparam logic [3:0] S_SPD_NUM  = 4'd3;
    localparam logic [3:0] S_SPD_DIV  = 4'd4;
    localparam logic [3:0] S_SPD_WAIT = 4'd5;
    localparam logic [3:0] S_POS_CHK  = 4'd6;
    localparam logic [3:0] S_POS_MUL  = 4'd7;
    localparam logic [3:0] S_POS_DIV  = 4'd8;
    localparam logic [3:0] S_POS_WAIT = 4'd9;
    localparam logic [3:0] S_FINAL    = 4'd10;

    // ---- control / state registers
    logic [3:0]               state_reg, state_next;
    logic [LEAD_W-1:0]        lead_reg, lead_next;
    logic [SPR_W-1:0]         spr_reg, spr_next;
    logic                     upneg_reg, upneg_next;
    logic                     run_reg, run_next;
    logic                     pulse_reg, pulse_next;
    logic                     dir_reg, dir_next;
    logic [PERIOD_WIDTH-1:0]  tick_reg, tick_next;
    logic [PERIOD_WIDTH-1:0]  hp_reg, hp_next;
    logic [STEP_W-1:0]        steps_reg, steps_next;
    logic                     lim_armed_reg, lim_armed_next;
    logic signed [POS_W-1:0]  lim_target_reg, lim_target_next;
    logic                     hom_reg, hom_next;
    logic signed [LOAD_W-1:0] home_load_reg, home_load_next;
    logic signed [POS_W-1:0]  pos_reg, pos_next;
    logic                     pos_ok_reg, pos_ok_next;
    logic                     match_reg, match_next;
    logic                     m_valid_reg, m_valid_next;

    // ---- payload registers (no reset)
    logic [1:0]               op_reg, op_next;
    logic [SPEED_W-1:0]       spd_reg, spd_next;
    logic signed [LOAD_W-1:0] thr_reg, thr_next;
    logic signed [POS_W-1:0]  tgt_reg, tgt_next;
    logic                     len_reg, len_next;
    logic signed [LOAD_W-1:0] ld_reg, ld_next;
    logic [MUL_P_W-1:0]       mul_reg, mul_next;
    logic [SPD_DEN_W-1:0]     den_reg, den_next;
    logic                     dpend_reg, dpend_next;

    logic                     o_pulse_reg, o_pulse_next;
    logic                     o_dir_reg, o_dir_next;
    logic                     o_run_reg, o_run_next;
    logic [STEP_W-1:0]        o_steps_reg, o_steps_next;
    logic signed [POS_W-1:0]  o_pos_reg, o_pos_next;
    logic                     o_hdone_reg, o_hdone_next;
    logic                     o_lstop_reg, o_lstop_next;

    // ---- datapath helpers
    logic                     cfg_wr;
    logic                     accept;
    logic [SPEED_W-1:0]       spd_mag;
    logic [STEP_W-1:0]        steps_abs;
    logic [PERIOD_WIDTH-1:0]  tick_inc;
    logic [MUL_A_W-1:0]       mul_a;
    logic [MUL_B_W-1:0]       mul_b;
    logic [MUL_P_W-1:0]       mul_prod;
    logic                     out_free;

    div_ctl_t                 div_ctl;
    div_sts_t                 div_sts;
    logic [DIV_W-1:0]         div_num;
    logic [DIV_W-1:0]         div_den;
    logic [QUOT_W-1:0]        div_quot;

    assign cfg_wr    = psel && penable && pwrite;
    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign pready    = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign spd_mag   = spd_reg[SPEED_W-1] ? (~spd_reg + SPEED_W'(1)) : spd_reg;
    assign steps_abs = steps_reg[STEP_W-1] ? (~steps_reg + STEP_W'(1)) : steps_reg;
    assign tick_inc  = tick_reg + PERIOD_WIDTH'(1);

    // shared multiplier, operands picked by the sequencer step
    always_comb begin
        case (state_reg)
            S_SPD_DEN: begin
                mul_a = MUL_A_W'(spr_reg);
                mul_b = MUL_B_W'(spd_mag);
            end
            S_SPD_NUM: begin
                mul_a = MUL_A_W'(lead_reg);
                mul_b = MUL_B_W'(HALF_K);
            end
            default: begin
                mul_a = steps_abs;
                mul_b = MUL_B_W'(lead_reg);
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;

    // shared divider
    assign div_ctl.start = (state_reg == S_SPD_DIV) || (state_reg == S_POS_DIV);
    assign div_ctl.qbits = (state_reg == S_SPD_DIV) ? QBITS_W'(PERIOD_WIDTH)
                                                     : QBITS_W'(POS_QBITS);
    assign div_num       = DIV_W'(mul_reg);
    assign div_den       = (state_reg == S_SPD_DIV) ? DIV_W'(den_reg) : DIV_W'(spr_reg);

    spg_div #(
        .W (DIV_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (div_ctl),
        .num     (div_num),
        .den     (div_den),
        .sts     (div_sts),
        .quot    (div_quot)
    );

    // ---- sequencer
    always_comb begin
        state_next      = state_reg;
        lead_next       = lead_reg;
        spr_next        = spr_reg;
        upneg_next      = upneg_reg;
        run_next        = run_reg;
        pulse_next      = pulse_reg;
        dir_next        = dir_reg;
        tick_next       = tick_reg;
        hp_next         = hp_reg;
        steps_next      = steps_reg;
        lim_armed_next  = lim_armed_reg;
        lim_target_next = lim_target_reg;
        hom_next        = hom_reg;
        home_load_next  = home_load_reg;
        pos_next        = pos_reg;
        pos_ok_next     = pos_ok_reg;
        match_next      = match_reg;
        m_valid_next    = m_valid_reg && !m_ready;

        op_next    = op_reg;
        spd_next   = spd_reg;
        thr_next   = thr_reg;
        tgt_next   = tgt_reg;
        len_next   = len_reg;
        ld_next    = ld_reg;
        mul_next   = mul_reg;
        den_next   = den_reg;
        dpend_next = dpend_reg;

        o_pulse_next = o_pulse_reg;
        o_dir_next   = o_dir_reg;
        o_run_next   = o_run_reg;
        o_steps_next = o_steps_reg;
        o_pos_next   = o_pos_reg;
        o_hdone_next = o_hdone_reg;
        o_lstop_next = o_lstop_reg;

        // register writes; a lead or steps_per_rev change makes the cached position stale
        if (cfg_wr) begin
            case (paddr[3:2])
                REG_LEAD: begin
                    lead_next   = pwdata[LEAD_W-1:0];
                    pos_ok_next = 1'b0;
                end
                REG_SPR: begin
                    spr_next    = pwdata[SPR_W-1:0];
                    pos_ok_next = 1'b0;
                end
                REG_UPNEG: begin
                    upneg_next  = pwdata[0];
                end
                default: begin
                end
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next    = s_op;
                    spd_next   = s_speed_um_s;
                    thr_next   = s_load_threshold;
                    tgt_next   = s_target_position_um;
                    len_next   = s_limit_enable;
                    ld_next    = s_load_sample;
                    match_next = 1'b0;
                    state_next = S_EXEC;
                end
            end

            S_EXEC: begin
                state_next = S_POS_CHK;
                case (op_reg)
                    OP_TICK: begin
                        if (run_reg) begin
                            if (tick_inc >= hp_reg) begin
                                // compare match: toggle, count on falling edge
                                tick_next  = '0;
                                pulse_next = !pulse_reg;
                                match_next = 1'b1;
                                if (pulse_reg) begin
                                    steps_next  = (dir_reg ^ upneg_reg) ?
                                                  (steps_reg - STEP_W'(1)) :
                                                  (steps_reg + STEP_W'(1));
                                    pos_ok_next = 1'b0;
                                end
                            end else begin
                                tick_next = tick_inc;
                            end
                        end
                    end
                    OP_SPEED, OP_HOME: begin
                        if (op_reg == OP_HOME) begin
                            hom_next       = 1'b1;
                            home_load_next = thr_reg;
                        end
                        dpend_next = (op_reg == OP_HOME) ? !upneg_reg : spd_reg[SPEED_W-1];
                        if (spd_mag <= SPEED_W'(1)) begin
                            run_next   = 1'b0;
                            pulse_next = 1'b0;
                        end else begin
                            state_next = S_SPD_DEN;
                        end
                    end
                    OP_LIMIT: begin
                        lim_armed_next  = len_reg;
                        lim_target_next = tgt_reg;
                    end
                    default: begin
                    end
                endcase
            end

            S_SPD_DEN: begin
                mul_next   = mul_prod;
                state_next = S_SPD_NUM;
            end

            S_SPD_NUM: begin
                den_next   = mul_reg[SPD_DEN_W-1:0];
                mul_next   = mul_prod;
                state_next = S_SPD_DIV;
            end

            S_SPD_DIV: begin
                state_next = S_SPD_WAIT;
            end

            S_SPD_WAIT: begin
                if (div_sts.done) begin
                    // overflow also covers a zero denominator
                    if (div_sts.ovf) begin
                        hp_next = PMAX;
                    end else if (div_quot == '0) begin
                        hp_next = PERIOD_WIDTH'(1);
                    end else begin
                        hp_next = div_quot[PERIOD_WIDTH-1:0];
                    end
                    tick_next  = hp_next - PERIOD_WIDTH'(1);
                    dir_next   = dpend_reg;
                    run_next   = 1'b1;
                    state_next = S_POS_CHK;
                end
            end

            S_POS_CHK: begin
                if (pos_ok_reg) begin
                    state_next = S_FINAL;
                end else if (spr_reg == '0 || steps_reg == '0) begin
                    pos_next    = '0;
                    pos_ok_next = 1'b1;
                    state_next  = S_FINAL;
                end else begin
                    state_next = S_POS_MUL;
                end
            end

            S_POS_MUL: begin
                mul_next   = mul_prod;
                state_next = S_POS_DIV;
            end

            S_POS_DIV: begin
                state_next = S_POS_WAIT;
            end

            S_POS_WAIT: begin
                if (div_sts.done) begin
                    // truncate toward zero, clamp to 32-bit signed
                    if (steps_reg[STEP_W-1]) begin
                        if (div_sts.ovf || div_quot[QUOT_W-1]) begin
                            pos_next = POS_MIN;
                        end else begin
                            pos_next = -$signed(div_quot);
                        end
                    end else begin
                        if (div_sts.ovf || div_quot[QUOT_W-1]) begin
                            pos_next = POS_MAX;
                        end else begin
                            pos_next = $signed(div_quot);
                        end
                    end
                    pos_ok_next = 1'b1;
                    state_next  = S_FINAL;
                end
            end

            S_FINAL: begin
                if (out_free) begin
                    o_lstop_next = 1'b0;
                    o_hdone_next = 1'b0;
                    if (match_reg) begin
                        if (lim_armed_reg &&
                            (($signed(pos_reg) > $signed(lim_target_reg)) != dir_reg)) begin
                            run_next       = 1'b0;
                            pulse_next     = 1'b0;
                            lim_armed_next = 1'b0;
                            o_lstop_next   = 1'b1;
                        end
                        if (hom_reg && ($signed(ld_reg) >= $signed(home_load_reg))) begin
                            run_next     = 1'b0;
                            pulse_next   = 1'b0;
                            steps_next   = '0;
                            pos_next     = '0;
                            pos_ok_next  = 1'b1;
                            hom_next     = 1'b0;
                            o_hdone_next = 1'b1;
                        end
                    end
                    o_pulse_next = pulse_next;
                    o_dir_next   = dir_reg;
                    o_run_next   = run_next;
                    o_steps_next = steps_next;
                    o_pos_next   = pos_next;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            lead_reg       <= LEAD_W'(5000);
            spr_reg        <= SPR_W'(200);
            upneg_reg      <= 1'b0;
            run_reg        <= 1'b0;
            pulse_reg      <= 1'b0;
            dir_reg        <= 1'b0;
            tick_reg       <= '0;
            hp_reg         <= '0;
            steps_reg      <= '0;
            lim_armed_reg  <= 1'b0;
            lim_target_reg <= '0;
            hom_reg        <= 1'b0;
            home_load_reg  <= '0;
            pos_reg        <= '0;
            pos_ok_reg     <= 1'b1;
            match_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            lead_reg       <= lead_next;
            spr_reg        <= spr_next;
            upneg_reg      <= upneg_next;
            run_reg        <= run_next;
            pulse_reg      <= pulse_next;
            dir_reg        <= dir_next;
            tick_reg       <= tick_next;
            hp_reg         <= hp_next;
            steps_reg      <= steps_next;
            lim_armed_reg  <= lim_armed_next;
            lim_target_reg <= lim_target_next;
            hom_reg        <= hom_next;
            home_load_reg  <= home_load_next;
            pos_reg        <= pos_next;
            pos_ok_reg     <= pos_ok_next;
            match_reg      <= match_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        spd_reg     <= spd_next;
        thr_reg     <= thr_next;
        tgt_reg     <= tgt_next;
        len_reg     <= len_next;
        ld_reg      <= ld_next;
        mul_reg     <= mul_next;
        den_reg     <= den_next;
        dpend_reg   <= dpend_next;
        o_pulse_reg <= o_pulse_next;
        o_dir_reg   <= o_dir_next;
        o_run_reg   <= o_run_next;
        o_steps_reg <= o_steps_next;
        o_pos_reg   <= o_pos_next;
        o_hdone_reg <= o_hdone_next;
        o_lstop_reg <= o_lstop_next;
    end

    // ---- register read-back
    always_comb begin
        case (paddr[3:2])
            REG_LEAD:  prdata = 32'(lead_reg);
            REG_SPR:   prdata = 32'(spr_reg);
            REG_UPNEG: prdata = 32'(upneg_reg);
            default:   prdata = '0;
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_step_pulse  = o_pulse_reg;
    assign m_direction   = o_dir_reg;
    assign m_running     = o_run_reg;
    assign m_step_count  = o_steps_reg;
    assign m_position_um = o_pos_reg;
    assign m_homing_done = o_hdone_reg;
    assign m_limit_stop  = o_lstop_reg;

endmodule

`default_nettype wire

[rtl/spg_checker.sv]
// ----------------------------------------------------------------------------
// spg_checker
// Port-level checks for the step/dir generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spg_checker
    import spg_pkg::*;
(
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      s_valid,
    input wire logic                      s_ready,
    input wire logic                      m_valid,
    input wire logic                      m_step_pulse,
    input wire logic                      m_running,
    input wire logic signed [STEP_W-1:0]  m_step_count,
    input wire logic signed [POS_W-1:0]   m_position_um,
    input wire logic                      m_homing_done,
    input wire logic                      m_limit_stop
);

    // one word in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a word is in flight");

    // a stopped motor always shows the pulse pin low
    a_stop_pulse_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_running) |-> !m_step_pulse)
        else $error("pulse high while motor stopped");

    // homing end stops the motor and zeroes count and position
    a_home_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_homing_done) |->
        (!m_running && m_step_count == '0 && m_position_um == '0))
        else $error("homing done without stop and zero");

    // limit stop leaves the motor stopped
    a_limit_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_limit_stop) |-> !m_running)
        else $error("limit stop while still running");

endmodule

bind stepper_pulse_generator_homing_top spg_checker u_spg_checker (.*);

`default_nettype wire
